// File: rtl/core/dshot4_pkg.sv
// ----------------------------------------------------------------------------
// dshot4_pkg
// Shared types, constants and the frame builder for the four-motor DShot
// frame encoder.
// ----------------------------------------------------------------------------
package dshot4_pkg;

    // Block dimensions
    localparam int MOTOR_COUNT = 4;
    localparam int FRAME_SLOTS = 18;
    localparam int DATA_SLOTS  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Last motor that takes part in the telemetry round-robin
    localparam logic [1:0] TELEM_LAST = 2'((MOTOR_COUNT > 4 ? 4 : MOTOR_COUNT) - 1);

    // Register indexes
    localparam logic [1:0] CFG_ONE_BIT_DUTY  = 2'd0;
    localparam logic [1:0] CFG_ZERO_BIT_DUTY = 2'd1;

    localparam logic [15:0] ONE_BIT_DUTY_RST  = 16'd14;
    localparam logic [15:0] ZERO_BIT_DUTY_RST = 16'd7;

    // One frame request
    typedef struct packed {
        logic [10:0] throttle_motor_1;
        logic [10:0] throttle_motor_2;
        logic [10:0] throttle_motor_3;
        logic [10:0] throttle_motor_4;
        logic        telemetry_enable;
    } t_frame_req;

    // One slot result
    typedef struct packed {
        logic [4:0]  slot_index;
        logic [15:0] duty_motor_1;
        logic [15:0] duty_motor_2;
        logic [15:0] duty_motor_3;
        logic [15:0] duty_motor_4;
        logic        telem_read_valid;
        logic [1:0]  telem_read_motor;
        logic        telem_all_read;
        logic        last_slot;
    } t_slot_out;

    // Built frames plus read report, handed from front to back
    typedef struct packed {
        logic [3:0][15:0] frames;
        logic             rd_valid;
        logic [1:0]       rd_motor;
        logic             rd_all;
    } t_frame_job;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // 11-bit value, telemetry bit, then XOR of the three nibbles
    function automatic logic [15:0] build_frame(logic [10:0] value, logic telem);
        logic [11:0] p;
        logic [3:0]  c;
        p = {value, telem};
        c = p[11:8] ^ p[7:4] ^ p[3:0];
        return {p, c};
    endfunction

endpackage

// File: rtl/core/dshot_four_motor_frame_encoder_core.sv
// ----------------------------------------------------------------------------
// dshot_four_motor_frame_encoder_core
// Four-motor DShot frame encoder: frame requests in, compare-value slots out.
// ----------------------------------------------------------------------------
// Each accepted frame request yields 18 slot results, one per cycle while the
// output is not stalled; the sustained request rate is set by the slot
// sequencer, which emits one slot a cycle. A two-entry job queue sits between
// the request side and the sequencer, so up to two built frames can wait while
// slots are still going out, and when a job is waiting the first slot of the
// next frame follows the last slot of the previous one with no gap. Duty
// registers are written through the plain write port (index 0 one-bit duty,
// index 1 zero-bit duty); the user must write them only while idle, the block does not enforce it.
// ----------------------------------------------------------------------------
module dshot_four_motor_frame_encoder_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  dshot4_pkg::t_frame_req i_req,
    output logic                   o_valid,
    input  logic                   i_stall,
    output dshot4_pkg::t_slot_out  o_slot,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_idx,
    input  logic [15:0]            i_cfg_data
);

    dshot4_pkg::t_frame_job    push_job;
    dshot4_pkg::t_frame_job    head_job;
    dshot4_pkg::t_queue_status q_status;
    logic                      push;
    logic                      pop;

    dshot4_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (push_job)
    );

    dshot4_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_head   (head_job),
        .o_status (q_status)
    );

    dshot4_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (head_job),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_slot     (o_slot)
    );

endmodule

// File: rtl/core/dshot4_front.sv
// ----------------------------------------------------------------------------
// dshot4_front
// Accepts frame requests, runs the telemetry round-robin and builds the
// four DShot frames that go into the job queue.
// ----------------------------------------------------------------------------
module dshot4_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  dshot4_pkg::t_frame_req   i_req,
    input  dshot4_pkg::t_queue_status i_q_status,
    output logic                     o_push,
    output dshot4_pkg::t_frame_job   o_job
);

    logic       r_divide_phase, n_divide_phase;
    logic [1:0] r_next_motor,   n_next_motor;
    logic       r_prev_valid,   n_prev_valid;
    logic [1:0] r_prev_motor,   n_prev_motor;

    logic        accept;
    logic [3:0]  telem_bits;
    logic [10:0] throttle [4];

    assign o_stall = i_q_status.full;
    assign accept  = i_valid && !i_q_status.full;
    assign o_push  = accept;

    assign throttle[0] = i_req.throttle_motor_1;
    assign throttle[1] = i_req.throttle_motor_2;
    assign throttle[2] = i_req.throttle_motor_3;
    assign throttle[3] = i_req.throttle_motor_4;

    // Telemetry round-robin: every second enabled request marks one motor,
    // then the frame build per motor
    always_comb begin
        n_divide_phase = r_divide_phase;
        n_next_motor   = r_next_motor;
        n_prev_valid   = r_prev_valid;
        n_prev_motor   = r_prev_motor;
        telem_bits     = 4'd0;
        o_job.rd_valid = 1'b0;
        o_job.rd_motor = 2'd0;
        o_job.rd_all   = 1'b0;
        if (i_req.telemetry_enable) begin
            if (r_divide_phase) begin
                telem_bits[r_next_motor] = 1'b1;
                if (r_prev_valid) begin
                    o_job.rd_valid = 1'b1;
                    o_job.rd_motor = r_prev_motor;
                    o_job.rd_all   = (r_prev_motor == dshot4_pkg::TELEM_LAST);
                end
                n_prev_motor   = r_next_motor;
                n_prev_valid   = 1'b1;
                n_next_motor   = (r_next_motor >= dshot4_pkg::TELEM_LAST) ? 2'd0
                                                                         : r_next_motor + 2'd1;
                n_divide_phase = 1'b0;
            end else begin
                n_divide_phase = 1'b1;
            end
        end
        for (int m = 0; m < 4; m++) begin
            o_job.frames[m] = dshot4_pkg::build_frame(throttle[m], telem_bits[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_divide_phase <= 1'b0;
            r_next_motor   <= 2'd0;
            r_prev_valid   <= 1'b0;
            r_prev_motor   <= 2'd0;
        end else if (accept) begin
            r_divide_phase <= n_divide_phase;
            r_next_motor   <= n_next_motor;
            r_prev_valid   <= n_prev_valid;
            r_prev_motor   <= n_prev_motor;
        end
    end

endmodule

// File: rtl/core/dshot4_queue.sv
// ----------------------------------------------------------------------------
// dshot4_queue
// Short job queue between the request front and the slot sequencer.
// ----------------------------------------------------------------------------
module dshot4_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  dshot4_pkg::t_frame_job    i_job,
    input  logic                      i_pop,
    output dshot4_pkg::t_frame_job    o_head,
    output dshot4_pkg::t_queue_status o_status
);

    localparam int PW = dshot4_pkg::QUEUE_PTR_W;
    localparam int CW = dshot4_pkg::QUEUE_CNT_W;

    dshot4_pkg::t_frame_job r_entry [dshot4_pkg::QUEUE_DEPTH];

    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;
    logic          do_push, do_pop;

    assign o_status.full  = (r_count == CW'(dshot4_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_entry[r_rd_ptr];

    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;

    // Pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(dshot4_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(dshot4_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage, no reset
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

endmodule

// File: rtl/core/dshot4_back.sv
// ----------------------------------------------------------------------------
// dshot4_back
// Slot sequencer: holds the duty registers, takes one job from the queue and
// emits one slot result per cycle while not stalled, MSB first, then the idle slots.
// ----------------------------------------------------------------------------
module dshot4_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_idx,
    input  logic [15:0]               i_cfg_data,
    input  dshot4_pkg::t_frame_job    i_head,
    input  dshot4_pkg::t_queue_status i_q_status,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_stall,
    output dshot4_pkg::t_slot_out     o_slot
);

    localparam logic [4:0] LAST_SLOT = 5'(dshot4_pkg::FRAME_SLOTS - 1);

    logic [15:0]            r_one_duty;
    logic [15:0]            r_zero_duty;
    logic                   r_busy, n_busy;
    logic [4:0]             r_slot, n_slot;
    dshot4_pkg::t_frame_job r_job;

    logic        out_done;
    logic        is_last;
    logic [3:0]  bit_pos;
    logic [15:0] duty [4];

    assign o_valid  = r_busy;
    assign out_done = r_busy && !i_stall;
    assign is_last  = (r_slot == LAST_SLOT);
    assign bit_pos  = ~r_slot[3:0];

    // Load a new job when idle or when the last slot leaves
    assign o_pop = !i_q_status.empty && (!r_busy || (out_done && is_last));

    always_comb begin
        n_busy = r_busy;
        n_slot = r_slot;
        if (o_pop) begin
            n_busy = 1'b1;
            n_slot = 5'd0;
        end else if (out_done) begin
            if (is_last) begin
                n_busy = 1'b0;
            end else begin
                n_slot = r_slot + 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_slot <= 5'd0;
        end else begin
            r_busy <= n_busy;
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    // Duty registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_duty  <= dshot4_pkg::ONE_BIT_DUTY_RST;
            r_zero_duty <= dshot4_pkg::ZERO_BIT_DUTY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dshot4_pkg::CFG_ONE_BIT_DUTY:  r_one_duty  <= i_cfg_data;
                dshot4_pkg::CFG_ZERO_BIT_DUTY: r_zero_duty <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Per-motor compare value for the current slot
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            duty[m] = 16'd0;
            if (m < dshot4_pkg::MOTOR_COUNT && r_slot < 5'(dshot4_pkg::DATA_SLOTS)) begin
                duty[m] = r_job.frames[m][bit_pos] ? r_one_duty : r_zero_duty;
            end
        end
    end

    // Result payload
    always_comb begin
        o_slot.slot_index       = r_slot;
        o_slot.duty_motor_1     = duty[0];
        o_slot.duty_motor_2     = duty[1];
        o_slot.duty_motor_3     = duty[2];
        o_slot.duty_motor_4     = duty[3];
        o_slot.telem_read_valid = (r_slot == 5'd0) && r_job.rd_valid;
        o_slot.telem_read_motor = (r_slot == 5'd0) ? r_job.rd_motor : 2'd0;
        o_slot.telem_all_read   = (r_slot == 5'd0) && r_job.rd_all;
        o_slot.last_slot        = is_last;
    end

endmodule
